@@ sv/btip_pkg.sv @@
// Shared widths, codes, defaults and the command type of the trie lookup block.
package btip_pkg;

  localparam int NODE_W  = 16;
  localparam int CHILD_W = 24;
  localparam int IP_W    = 32;
  localparam int SEG_W   = 24;
  localparam int OFFS_W  = 27;
  localparam int LEVEL_W = 5;

  // The walk starts at the most significant address bit.
  localparam logic [LEVEL_W-1:0] TOP_LEVEL = LEVEL_W'(IP_W - 1);

  localparam int NODE_DEPTH_DEF   = 65536;
  localparam int RECORD_BYTES_DEF = 3;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  // One classified request as it waits between the front and the back.
  typedef struct packed {
    logic               is_lookup;
    logic               wr_ok;
    logic [NODE_W-1:0]  node_index;
    logic [CHILD_W-1:0] left_child;
    logic [CHILD_W-1:0] right_child;
    logic [IP_W-1:0]    ip_addr;
  } cmd_t;

endpackage

@@ sv/binary_trie_ip_lookup_core.sv @@
// Top level of the binary trie IPv4 prefix lookup block.
//
// Requests arrive on the input channel (in_valid / in_stall). A write request
// (req_type 0) stores one node, a left and a right child, at node_index. A
// lookup request (req_type 1) walks the trie from node 0, one address bit per
// level from bit 31 down, and produces exactly one result transfer on the
// output channel (out_valid / out_stall). Writes produce no result.
// A front stage classifies each request into a two-entry queue; the back
// stage drains it, so requests keep arriving while a walk is under way.
// In the back stage a write is stored as it leaves the queue. A lookup
// issues the root read, then reads the single-port node table once per
// trie level visited. When the receiver stalls, the result holds in the
// output register and the walk that finishes next waits; the queue then
// fills and in_stall rises. The user must write segment_count through
// cfg_wr_en / cfg_wr_data only while the block is idle; the block itself
// does not enforce this. Synchronous reset empties the queue, drops any
// result and clears segment_count; the node table keeps no reset and must
// be written before the nodes a lookup reaches.
module binary_trie_ip_lookup_core #(
  parameter int NODE_DEPTH   = btip_pkg::NODE_DEPTH_DEF,
  parameter int RECORD_BYTES = btip_pkg::RECORD_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [btip_pkg::SEG_W-1:0]   cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         req_type,
  input  logic [btip_pkg::NODE_W-1:0]  node_index,
  input  logic [btip_pkg::CHILD_W-1:0] left_child,
  input  logic [btip_pkg::CHILD_W-1:0] right_child,
  input  logic [btip_pkg::IP_W-1:0]    ip_addr,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         found,
  output logic [btip_pkg::CHILD_W-1:0] leaf_value,
  output logic [btip_pkg::OFFS_W-1:0]  record_offset
);

  logic [btip_pkg::SEG_W-1:0] segment_count;
  logic                       q_valid;
  btip_pkg::cmd_t             q_cmd;
  logic                       q_pop;

  // Child values at or above segment_count are leaves.
  always_ff @(posedge clk) begin
    if (rst) begin
      segment_count <= '0;
    end else if (cfg_wr_en) begin
      segment_count <= cfg_wr_data;
    end
  end

  btip_front #(
    .NODE_DEPTH (NODE_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .node_index  (node_index),
    .left_child  (left_child),
    .right_child (right_child),
    .ip_addr     (ip_addr),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_pop       (q_pop)
  );

  btip_back #(
    .NODE_DEPTH   (NODE_DEPTH),
    .RECORD_BYTES (RECORD_BYTES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .segment_count (segment_count),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .found         (found),
    .leaf_value    (leaf_value),
    .record_offset (record_offset)
  );

endmodule

@@ sv/btip_front.sv @@
// Input side: accepts requests, classifies them and keeps a two-entry command queue.
module btip_front #(
  parameter int NODE_DEPTH = btip_pkg::NODE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         req_type,
  input  logic [btip_pkg::NODE_W-1:0]  node_index,
  input  logic [btip_pkg::CHILD_W-1:0] left_child,
  input  logic [btip_pkg::CHILD_W-1:0] right_child,
  input  logic [btip_pkg::IP_W-1:0]    ip_addr,
  output logic                         q_valid,
  output btip_pkg::cmd_t               q_cmd,
  input  logic                         q_pop
);

  localparam logic [btip_pkg::CHILD_W:0] DepthLim = (btip_pkg::CHILD_W + 1)'(NODE_DEPTH);

  btip_pkg::cmd_t q [2];
  logic           wptr;
  logic           rptr;
  logic [1:0]     cnt;
  logic           push;
  btip_pkg::cmd_t cmd_in;

  assign in_stall = (cnt == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt != 2'd0);
  assign q_cmd    = q[rptr];

  always_comb begin
    cmd_in.is_lookup   = (req_type == btip_pkg::REQ_LOOKUP);
    // Writes past the end of the table are dropped later on.
    cmd_in.wr_ok       = ({(btip_pkg::CHILD_W + 1 - btip_pkg::NODE_W)'(0), node_index}
                          < DepthLim);
    cmd_in.node_index  = node_index;
    cmd_in.left_child  = left_child;
    cmd_in.right_child = right_child;
    cmd_in.ip_addr     = ip_addr;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (q_pop) begin
        rptr <= !rptr;
      end
      case ({push, q_pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

@@ sv/btip_back.sv @@
// Execution side: node table, trie walk sequencer and the result register.
module btip_back #(
  parameter int NODE_DEPTH   = btip_pkg::NODE_DEPTH_DEF,
  parameter int RECORD_BYTES = btip_pkg::RECORD_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [btip_pkg::SEG_W-1:0]   segment_count,
  input  logic                         q_valid,
  input  btip_pkg::cmd_t               q_cmd,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         found,
  output logic [btip_pkg::CHILD_W-1:0] leaf_value,
  output logic [btip_pkg::OFFS_W-1:0]  record_offset
);

  localparam int AW      = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;
  localparam int RecMul  = 2 * RECORD_BYTES - 1;
  localparam int EntryW  = 2 * btip_pkg::CHILD_W;
  localparam logic [btip_pkg::CHILD_W:0] DepthLim = (btip_pkg::CHILD_W + 1)'(NODE_DEPTH);

  typedef enum logic {ST_IDLE, ST_WALK} state_t;

  state_t                        state;
  logic [EntryW-1:0]             mem [NODE_DEPTH];
  logic [EntryW-1:0]             rdata;
  logic                          rd_en;
  logic [AW-1:0]                 rd_addr;
  logic                          we;
  logic [AW-1:0]                 wr_addr;
  logic [btip_pkg::IP_W-1:0]     ip;
  logic [btip_pkg::LEVEL_W-1:0]  level;
  logic [btip_pkg::OFFS_W-1:0]   seg_scaled;
  logic [btip_pkg::CHILD_W-1:0]  child;
  logic                          is_leaf;
  logic                          in_table;
  logic                          walk_end;
  logic                          out_free;
  logic [btip_pkg::OFFS_W-1:0]   offset_sum;

  assign out_free = !out_valid || !out_stall;
  assign q_pop    = (state == ST_IDLE) && q_valid;

  // The child picked by the current address bit decides the next step.
  assign child    = ip[level] ? rdata[EntryW-1:btip_pkg::CHILD_W]
                              : rdata[btip_pkg::CHILD_W-1:0];
  assign is_leaf  = (child >= segment_count);
  assign in_table = ({1'b0, child} < DepthLim);
  assign walk_end = is_leaf || !in_table || (level == '0);

  assign we      = q_pop && !q_cmd.is_lookup && q_cmd.wr_ok;
  assign wr_addr = AW'({(btip_pkg::CHILD_W - btip_pkg::NODE_W)'(0), q_cmd.node_index});
  assign rd_en   = (q_pop && q_cmd.is_lookup) || ((state == ST_WALK) && !walk_end);
  assign rd_addr = (state == ST_IDLE) ? '0 : AW'(child);

  assign offset_sum = btip_pkg::OFFS_W'(child) + seg_scaled;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= {q_cmd.right_child, q_cmd.left_child};
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // The user must change segment_count only while idle; the block does not enforce it.
  always_ff @(posedge clk) begin
    seg_scaled <= btip_pkg::OFFS_W'(btip_pkg::OFFS_W'(segment_count)
                                    * btip_pkg::OFFS_W'(RecMul));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // A finishing walk refills the result register in the cycle it drains.
      if ((state == ST_WALK) && walk_end && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_pop && q_cmd.is_lookup) begin
            ip    <= q_cmd.ip_addr;
            level <= btip_pkg::TOP_LEVEL;
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (walk_end) begin
            if (out_free) begin
              found         <= is_leaf;
              leaf_value    <= is_leaf ? child : '0;
              record_offset <= is_leaf ? offset_sum : '0;
              state         <= ST_IDLE;
            end
          end else begin
            level <= level - btip_pkg::LEVEL_W'(1);
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (leaf_value == '0) && (record_offset == '0))
    else $error("miss result carries nonzero payload");

  a_hit_is_leaf: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |-> (leaf_value >= segment_count))
    else $error("hit result below segment count");

  a_level_steps: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_WALK) && !walk_end) |=>
      (level == $past(level) - btip_pkg::LEVEL_W'(1)))
    else $error("walk level did not step down");

  a_no_write_in_walk: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> !we)
    else $error("table write during a walk");

endmodule
